/* design/rlb_pkg.sv */
// ----------------------------------------------------------------------------
// rlb_pkg
// shared widths, lane count and parameter defaults of the ring line buffer
// ----------------------------------------------------------------------------
`default_nettype none

package rlb_pkg;

    // payload field widths
    localparam int FIELD_BITS = 16;
    localparam int BASE_BITS  = 8;
    localparam int COUNT_BITS = 16;

    // words fetched per read, one result field each
    localparam int LANES = 3;

    // parameter defaults
    localparam int LINE_WORDS_DEF = 256;
    localparam int WORD_BITS_DEF  = 16;

    // fill count saturation point
    localparam logic [COUNT_BITS-1:0] FILL_MAX = '1;

endpackage

`default_nettype wire

/* design/rlb_in_if.sv */
// ----------------------------------------------------------------------------
// rlb_in_if
// request channel into the ring line buffer: write, read and base selection
// ----------------------------------------------------------------------------
`default_nettype none

interface rlb_in_if;
    import rlb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] data_word;
    logic                  store_en;
    logic                  fetch_en;
    logic                  reuse_select;
    logic [BASE_BITS-1:0]  new_base;
    logic [BASE_BITS-1:0]  reuse_base;
    logic [COUNT_BITS-1:0] need_count;

    modport source (
        output valid, data_word, store_en, fetch_en, reuse_select,
               new_base, reuse_base, need_count,
        input  ready
    );

    modport sink (
        input  valid, data_word, store_en, fetch_en, reuse_select,
               new_base, reuse_base, need_count,
        output ready
    );

endinterface

`default_nettype wire

/* design/rlb_out_if.sv */
// ----------------------------------------------------------------------------
// rlb_out_if
// result channel out of the ring line buffer: fetched words and ready flag
// ----------------------------------------------------------------------------
`default_nettype none

interface rlb_out_if;
    import rlb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] word_0;
    logic [FIELD_BITS-1:0] word_1;
    logic [FIELD_BITS-1:0] word_2;
    logic                  ready_res;

    modport source (
        output valid, word_0, word_1, word_2, ready_res,
        input  ready
    );

    modport sink (
        input  valid, word_0, word_1, word_2, ready_res,
        output ready
    );

endinterface

`default_nettype wire

/* design/rlb_ram.sv */
// ----------------------------------------------------------------------------
// rlb_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rlb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/ring_line_buffer_multi_read_core.sv */
// ----------------------------------------------------------------------------
// ring_line_buffer_multi_read_core
// circular line store feeding a convolution: a request may write a word at
// a wrapping pointer and fetch three consecutive words from a chosen base
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------
//  item    | in  | valid / ready | data_word, store/fetch enables, reuse
//          |     |               | select, new/reuse base, need_count
//  res     | out | valid / ready | word_0..word_2, ready_res
//
//  one request per cycle sustained while no result stalls; a request passes
//  the ram read stage, then the output register, before its result is valid
//  each lane has its own copy of the line in a ram, all copies written alike
//  reset clears pointer, fill count, wrap flag and held words at once; no
//  clearing pass: an entry not yet written reads as zero by pointer and flag
//  a stalled result holds the read stage, which then takes no request
//
`default_nettype none

module ring_line_buffer_multi_read_core #(
    parameter int LINE_WORDS = rlb_pkg::LINE_WORDS_DEF,
    parameter int WORD_BITS  = rlb_pkg::WORD_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rlb_in_if.sink    item,
    rlb_out_if.source res
);

    import rlb_pkg::*;

    localparam int AW = $clog2(LINE_WORDS);
    // stored width: the data field never carries more than its own width
    localparam int SW = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;

    // ------------------------------------------------------------------
    // base reduction table: base field modulo line length, constant
    // ------------------------------------------------------------------
    logic [AW-1:0] base_tab [2**BASE_BITS];

    for (genvar g = 0; g < 2**BASE_BITS; g++)
    begin : g_base_tab
        localparam int BASE_MOD = g % LINE_WORDS;
        assign base_tab[g] = BASE_MOD[AW-1:0];
    end

    // ------------------------------------------------------------------
    // state registers
    // ------------------------------------------------------------------
    logic [AW-1:0]         wp_reg,       wp_next;
    logic                  wrapped_reg,  wrapped_next;
    logic [COUNT_BITS-1:0] fill_reg,     fill_next;

    // read stage
    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_read_reg;
    logic                  s1_ready_reg;
    logic [SW-1:0]         s1_data_reg;
    logic [LANES-1:0]      s1_hit_reg;
    logic [LANES-1:0]      s1_written_reg;

    // held words and output register
    logic [SW-1:0]         held_reg     [LANES];
    logic [SW-1:0]         held_next    [LANES];
    logic                  out_valid_reg, out_valid_next;
    logic [SW-1:0]         out_word_reg [LANES];
    logic                  out_rdy_reg;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic accept;
    logic s1_adv;

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || res.ready);
    assign item.ready = !s1_valid_reg || s1_adv;
    assign accept     = item.valid && item.ready;

    // ------------------------------------------------------------------
    // request stage: addresses, write, fill count
    // ------------------------------------------------------------------
    logic [BASE_BITS-1:0]  base_raw;
    logic [AW-1:0]         base_mod;
    logic [AW:0]           lane_sum  [LANES];
    logic [AW-1:0]         lane_addr [LANES];
    logic [LANES-1:0]      lane_hit;
    logic [LANES-1:0]      lane_written;
    logic [COUNT_BITS-1:0] fill_after;
    logic                  wp_at_end;
    logic [SW-1:0]         wr_word;

    assign base_raw  = item.reuse_select ? item.reuse_base : item.new_base;
    assign base_mod  = base_tab[base_raw];
    assign wp_at_end = (wp_reg == AW'(LINE_WORDS - 1));
    assign wr_word   = item.data_word[SW-1:0];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            // base below line length, lane offset small: one wrap at most
            lane_sum[i] = {1'b0, base_mod} + (AW+1)'(i);
            if (lane_sum[i] >= (AW+1)'(LINE_WORDS))
            begin
                lane_addr[i] = AW'(lane_sum[i] - (AW+1)'(LINE_WORDS));
            end
            else
            begin
                lane_addr[i] = lane_sum[i][AW-1:0];
            end
            // same-request write goes straight to the read
            lane_hit[i]     = item.store_en && (lane_addr[i] == wp_reg);
            // entries below the pointer, or all after a wrap, hold real data
            lane_written[i] = wrapped_reg || (lane_addr[i] < wp_reg);
        end
    end

    always_comb
    begin
        fill_after = fill_reg;
        if (item.store_en && (fill_reg != FILL_MAX))
        begin
            fill_after = fill_reg + COUNT_BITS'(1);
        end
    end

    always_comb
    begin
        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        fill_next    = fill_reg;
        if (accept)
        begin
            fill_next = fill_after;
            if (item.store_en)
            begin
                wp_next      = wp_at_end ? '0 : wp_reg + AW'(1);
                wrapped_next = wrapped_reg || wp_at_end;
            end
        end
    end

    // ------------------------------------------------------------------
    // line copies, one per lane
    // ------------------------------------------------------------------
    logic [SW-1:0] ram_data [LANES];

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane_ram
        rlb_ram #(
            .WIDTH (SW),
            .DEPTH (LINE_WORDS)
        ) u_ram (
            .clk     (clk),
            .wr_en   (accept && item.store_en),
            .wr_addr (wp_reg),
            .wr_data (wr_word),
            .rd_en   (accept && item.fetch_en),
            .rd_addr (lane_addr[l]),
            .rd_data (ram_data[l])
        );
    end

    // ------------------------------------------------------------------
    // read stage: merge forwarded word, unwritten entries read as zero
    // ------------------------------------------------------------------
    logic [SW-1:0] fetched [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (s1_hit_reg[i])
            begin
                fetched[i] = s1_data_reg;
            end
            else if (s1_written_reg[i])
            begin
                fetched[i] = ram_data[i];
            end
            else
            begin
                fetched[i] = '0;
            end
            held_next[i] = (s1_adv && s1_read_reg) ? fetched[i] : held_reg[i];
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else
        begin
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            fill_reg      <= fill_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < LANES; i++)
            begin
                held_reg[i] <= held_next[i];
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_read_reg    <= item.fetch_en;
            s1_ready_reg   <= (fill_after >= item.need_count);
            s1_data_reg    <= wr_word;
            s1_hit_reg     <= lane_hit;
            s1_written_reg <= lane_written;
        end
        if (s1_adv)
        begin
            out_rdy_reg <= s1_ready_reg;
            for (int i = 0; i < LANES; i++)
            begin
                out_word_reg[i] <= s1_read_reg ? fetched[i] : held_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // result channel
    // ------------------------------------------------------------------
    assign res.valid     = out_valid_reg;
    assign res.word_0    = FIELD_BITS'(out_word_reg[0]);
    assign res.word_1    = FIELD_BITS'(out_word_reg[1]);
    assign res.word_2    = FIELD_BITS'(out_word_reg[2]);
    assign res.ready_res = out_rdy_reg;

endmodule

`default_nettype wire

/* test/ring_line_buffer_multi_read_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_line_buffer_multi_read_core_tb
// self-checking bench for the ring line buffer: a clocked driver feeds
// requests from a backlog, a tracking line model predicts the fetched words
// and the ready flag, and a clocked monitor compares every result in order
// ----------------------------------------------------------------------------

module ring_line_buffer_multi_read_core_tb;
    import rlb_pkg::*;

    localparam int LINE_WORDS = LINE_WORDS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [FIELD_BITS-1:0] data_word;
        logic                  store_en;
        logic                  fetch_en;
        logic                  reuse_select;
        logic [BASE_BITS-1:0]  new_base;
        logic [BASE_BITS-1:0]  reuse_base;
        logic [COUNT_BITS-1:0] need_count;
    } line_req_t;

    typedef struct packed {
        logic [LANES-1:0][FIELD_BITS-1:0] words;
        logic                             ready_res;
    } line_res_t;

    logic clk;
    logic rst_n;

    rlb_in_if  item_ch ();
    rlb_out_if res_ch ();

    ring_line_buffer_multi_read_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .res   (res_ch)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // tracking copy of the line, advanced once per accepted request
    logic [FIELD_BITS-1:0] line_copy [LINE_WORDS];
    logic [FIELD_BITS-1:0] held [LANES];
    int                    wr_ptr;
    logic [COUNT_BITS-1:0] fill_cnt;

    // requests waiting to be driven, and fetched words still owed by the block
    line_req_t req_backlog [$];
    line_res_t due_results [$];

    // generation-side view of pointer and fill count, used to aim the stimulus
    int plan_fill;
    int plan_wp;

    line_req_t cur_req;
    line_res_t want;
    logic      steady;
    int        err_count;
    int        n_posted;
    int        n_accepted;
    int        n_writes;
    int        n_reads;
    int        n_checked;
    int        cycles;

    // one request: optional write at the pointer, then optional fetch of
    // LANES words from the selected base; the write is seen by the fetch
    function automatic line_res_t advance_line(line_req_t r);
        line_res_t o;
        int        base;
        if (r.store_en)
        begin
            line_copy[wr_ptr] = r.data_word;
            wr_ptr = (wr_ptr + 1) % LINE_WORDS;
            if (fill_cnt != FILL_MAX)
                fill_cnt = fill_cnt + 1'b1;
        end
        if (r.fetch_en)
        begin
            base = (r.reuse_select ? int'(r.reuse_base) : int'(r.new_base)) % LINE_WORDS;
            for (int i = 0; i < LANES; i++)
                held[i] = line_copy[(base + i) % LINE_WORDS];
        end
        for (int i = 0; i < LANES; i++)
            o.words[i] = held[i];
        o.ready_res = (fill_cnt >= r.need_count);
        return o;
    endfunction

    function automatic line_req_t mk_req(logic [FIELD_BITS-1:0] data, logic we, logic re,
                                         logic rs, logic [BASE_BITS-1:0] nb,
                                         logic [BASE_BITS-1:0] rb,
                                         logic [COUNT_BITS-1:0] rc);
        line_req_t r;
        r.data_word    = data;
        r.store_en     = we;
        r.fetch_en     = re;
        r.reuse_select = rs;
        r.new_base     = nb;
        r.reuse_base   = rb;
        r.need_count   = rc;
        return r;
    endfunction

    task automatic post(line_req_t r);
        req_backlog.push_back(r);
        n_posted++;
        if (r.store_en)
        begin
            plan_wp = (plan_wp + 1) % LINE_WORDS;
            if (plan_fill < int'(FILL_MAX))
                plan_fill++;
        end
    endtask

    // base aimed at the line end, the write pointer, or anywhere
    function automatic logic [BASE_BITS-1:0] pick_base();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            return BASE_BITS'($urandom_range(LINE_WORDS - 3, LINE_WORDS - 1));
        else if (pick == 1)
            return BASE_BITS'((plan_wp + LINE_WORDS - $urandom_range(0, 3)) % LINE_WORDS);
        else
            return BASE_BITS'($urandom_range(0, LINE_WORDS - 1));
    endfunction

    task automatic post_random(bit all_writes);
        line_req_t r;
        int        next_fill;
        int        pick;
        int        target;
        r.data_word    = FIELD_BITS'($urandom_range(0, 65535));
        r.store_en     = all_writes || ($urandom_range(0, 99) < 70);
        r.fetch_en     = $urandom_range(0, 99) < 65;
        r.reuse_select = 1'($urandom_range(0, 1));
        r.new_base     = pick_base();
        r.reuse_base   = pick_base();
        next_fill = plan_fill;
        if (r.store_en && plan_fill < int'(FILL_MAX))
            next_fill++;
        // count zero, full scale, random or near fill so ready flips both ways
        pick = $urandom_range(0, 5);
        if (pick == 0)
            target = 0;
        else if (pick == 1)
            target = int'(FILL_MAX);
        else if (pick == 2)
            target = int'($urandom_range(0, 65535));
        else
            target = next_fill + int'($urandom_range(0, 4)) - 2;
        if (target < 0)
            target = 0;
        if (target > int'(FILL_MAX))
            target = int'(FILL_MAX);
        r.need_count = COUNT_BITS'(target);
        post(r);
    endtask

    // wait for every posted request to be taken and every result to come back
    task automatic drain();
        while (n_accepted != n_posted || due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic report(string what, int exp_val, int act_val);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_val,
                 act_val);
        err_count++;
    endtask

    // driver: a held request stays on the channel until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                due_results.push_back(advance_line(cur_req));
                n_accepted++;
                if (cur_req.store_en)
                    n_writes++;
                if (cur_req.fetch_en)
                    n_reads++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (req_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 33))
                begin
                    cur_req = req_backlog.pop_front();
                    item_ch.valid        <= 1'b1;
                    item_ch.data_word    <= cur_req.data_word;
                    item_ch.store_en     <= cur_req.store_en;
                    item_ch.fetch_en     <= cur_req.fetch_en;
                    item_ch.reuse_select <= cur_req.reuse_select;
                    item_ch.new_base     <= cur_req.new_base;
                    item_ch.reuse_base   <= cur_req.reuse_base;
                    item_ch.need_count   <= cur_req.need_count;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each taken result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (due_results.size() == 0)
                begin
                    report("unexpected result, word_0", 0, res_ch.word_0);
                end
                else
                begin
                    want = due_results.pop_front();
                    n_checked++;
                    if (res_ch.word_0 !== want.words[0])
                        report("word_0", want.words[0], res_ch.word_0);
                    if (res_ch.word_1 !== want.words[1])
                        report("word_1", want.words[1], res_ch.word_1);
                    if (res_ch.word_2 !== want.words[2])
                        report("word_2", want.words[2], res_ch.word_2);
                    if (res_ch.ready_res !== want.ready_res)
                        report("ready_res", want.ready_res, res_ch.ready_res);
                end
            end
            res_ch.ready <= steady || ($urandom_range(0, 99) >= 33);
        end
    end

    // run guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.data_word    = '0;
        item_ch.store_en     = 1'b0;
        item_ch.fetch_en     = 1'b0;
        item_ch.reuse_select = 1'b0;
        item_ch.new_base     = '0;
        item_ch.reuse_base   = '0;
        item_ch.need_count   = '0;
        res_ch.ready         = 1'b0;
        steady     = 1'b0;
        err_count  = 0;
        n_posted   = 0;
        n_accepted = 0;
        n_writes   = 0;
        n_reads    = 0;
        n_checked  = 0;
        cycles     = 0;
        plan_fill  = 0;
        plan_wp    = 0;
        wr_ptr     = 0;
        fill_cnt   = '0;
        for (int i = 0; i < LINE_WORDS; i++)
            line_copy[i] = '0;
        for (int i = 0; i < LANES; i++)
            held[i] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reads of a fresh line, extremes of data, base at the line
        // end, both base selects, write seen by its own read, held repeats,
        // required count of zero and of full scale
        post(mk_req(16'h0000, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 16'h0000));
        post(mk_req(16'h0000, 1'b0, 1'b1, 1'b1, 8'h00, 8'hFF, 16'h0001));
        post(mk_req(16'hFFFF, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0001));
        post(mk_req(16'h0000, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 16'hFFFF));
        post(mk_req(16'hA5A5, 1'b1, 1'b1, 1'b0, 8'h02, 8'h00, 16'h0002));
        post(mk_req(16'h5A5A, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 16'h0003));
        post(mk_req(16'h1234, 1'b1, 1'b1, 1'b1, 8'h00, 8'h03, 16'h0004));
        post(mk_req(16'hFFFF, 1'b1, 1'b1, 1'b0, 8'hFF, 8'h00, 16'h0006));
        post(mk_req(16'h8001, 1'b1, 1'b1, 1'b1, 8'h00, 8'hFE, 16'hFFFF));
        post(mk_req(16'h0000, 1'b0, 1'b1, 1'b0, 8'hFF, 8'h00, 16'h0000));
        post(mk_req(16'h7FFF, 1'b1, 1'b1, 1'b0, 8'h06, 8'h00, 16'h0007));
        post(mk_req(16'h0000, 1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF, 16'h0008));
        post(mk_req(16'hC3C3, 1'b1, 1'b1, 1'b1, 8'hAA, 8'h55, 16'h0009));
        post(mk_req(16'h3C3C, 1'b1, 1'b1, 1'b0, 8'h55, 8'hAA, 16'h0009));

        // sender holds off until the block has answered everything
        drain();

        // random mix, pointer wraps the line
        repeat (600) post_random(1'b0);
        drain();

        // back-to-back writes with no stalls on either side
        steady <= 1'b1;
        repeat (150) post_random(1'b1);
        drain();
        steady <= 1'b0;

        // random mix with stalls again
        repeat (60) post_random(1'b0);
        drain();

        repeat (8) @(posedge clk);

        $display("tb: %0d results checked from %0d requests (%0d writes, %0d reads)",
                 n_checked, n_accepted, n_writes, n_reads);
        $display("tb: line pointer wrapped, bases at the line end, stalls on both sides");
        if (err_count == 0 && due_results.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
